// ===== src/pcls_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pcls_pkg
// Shared types, constants and helper functions for the packed code lookup
// table scorer: config layout, item metadata and saturating clamp algebra.
// ============================================================================
package pcls_pkg;

  // Field widths
  localparam int BITS_W  = 3;
  localparam int CNT_W   = 11;
  localparam int VEC_W   = 24;
  localparam int SCORE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int LANES   = 4;
  localparam int LANE_W  = 2;
  localparam int FILL_W  = 2;
  localparam int RES_W   = 2;
  localparam int WORD_W  = RES_W + BYTE_W;
  localparam int TOTAL_W = 4;
  localparam int NCODE_W = 3;
  localparam int CODE_W  = 4;
  localparam int WIDE_W  = 35;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_DIM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_VECTOR = 2'd2;

  // Configuration reset values
  localparam logic [BITS_W-1:0] RST_BITS_PER_DIM     = 3'd4;
  localparam logic [CNT_W-1:0]  RST_DIM_COUNT        = 11'd1024;
  localparam logic [CNT_W-1:0]  RST_BYTES_PER_VECTOR = 11'd512;

  // Input word modes
  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // Result queue depth
  localparam int RESULT_DEPTH = 8;
  localparam int QPTR_W       = 3;
  localparam int QCNT_W       = 4;
  localparam int PEND_W       = 5;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t SCORE_MAX = 35'sd2147483647;
  localparam wide_t SCORE_MIN = -35'sd2147483648;

  typedef struct packed {
    logic [BITS_W-1:0] bits_per_dim;
    logic [CNT_W-1:0]  dim_count;
    logic [CNT_W-1:0]  bytes_per_vector;
  } cfg_t;

  // Metadata of one lookup group, aligned with the table read data
  typedef struct packed {
    logic             last;
    logic [VEC_W-1:0] vindex;
    logic [LANES-1:0] lane_en;
    logic [LANE_W-1:0] base_bank;
  } item_meta_t;

  // x -> clamp(x + s, lo, hi)
  typedef struct packed {
    wide_t s;
    wide_t lo;
    wide_t hi;
  } clamp_fn_t;

  localparam clamp_fn_t CLAMP_IDENTITY = '{s: '0, lo: SCORE_MIN, hi: SCORE_MAX};

  function automatic wide_t clamp_wide(wide_t v, wide_t lo, wide_t hi);
    wide_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Apply f1 then f2; nested clamps fold into one clamp with clamped bounds
  function automatic clamp_fn_t compose(clamp_fn_t f1, clamp_fn_t f2);
    clamp_fn_t f;
    f.s  = f1.s + f2.s;
    f.lo = clamp_wide(f1.lo + f2.s, f2.lo, f2.hi);
    f.hi = clamp_wide(f1.hi + f2.s, f2.lo, f2.hi);
    return f;
  endfunction

  // Whole codes held in a word of total bits for a given code width
  function automatic logic [NCODE_W-1:0] code_count(logic [TOTAL_W-1:0] total,
                                                    logic [BITS_W-1:0] bits);
    logic [NCODE_W-1:0] n;
    case (bits)
      3'd2: n = NCODE_W'(total >> 1);
      3'd3: begin
        case (total)
          4'd0, 4'd1, 4'd2: n = 3'd0;
          4'd3, 4'd4, 4'd5: n = 3'd1;
          4'd6, 4'd7, 4'd8: n = 3'd2;
          default:          n = 3'd3;
        endcase
      end
      3'd4: n = NCODE_W'(total >> 2);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/pcls_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pcls_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are not reset.
// ============================================================================
module pcls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pcls_unpack.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pcls_unpack
// Front end: accepts words, writes table entries, unpacks code bits from the
// byte stream, tracks dimension/byte/vector counters and issues up to four
// banked table reads per cycle.
// ============================================================================
module pcls_unpack #(
  parameter int MAX_DIMS   = 1024,
  parameter int MAX_LEVELS = 16,
  parameter int ENTRY_BITS = 16,
  parameter int ADDR_W     = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  pcls_pkg::cfg_t                             cfg,
  input  logic                                       item_valid,
  output logic                                       item_stall,
  input  logic                                       mode,
  input  logic [9:0]                                 table_dim,
  input  logic [3:0]                                 table_level,
  input  logic signed [15:0]                         table_value,
  input  logic [pcls_pkg::BYTE_W-1:0]                data_byte,
  input  logic                                       congested,
  output logic [pcls_pkg::LANES-1:0]                 wr_en,
  output logic [ADDR_W-1:0]                          wr_addr,
  output logic [ENTRY_BITS-1:0]                      wr_data,
  output logic [pcls_pkg::LANES-1:0][ADDR_W-1:0]     rd_addr,
  output pcls_pkg::item_meta_t                       meta
);

  localparam int ROWS   = (MAX_DIMS + pcls_pkg::LANES - 1) / pcls_pkg::LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LVL_W  = $clog2(MAX_LEVELS);
  localparam int DIM_W  = pcls_pkg::CNT_W + 1;
  localparam longint EMAX = (64'sd1 <<< (ENTRY_BITS - 1)) - 64'sd1;
  localparam longint EMIN = -EMAX - 64'sd1;

  // Stream state
  logic [pcls_pkg::RES_W-1:0]  res;
  logic [pcls_pkg::FILL_W-1:0] fill;
  logic [pcls_pkg::CNT_W-1:0]  dim_cnt;
  logic [pcls_pkg::CNT_W-1:0]  byte_cnt;
  logic [pcls_pkg::VEC_W-1:0]  vec_cnt;

  logic [pcls_pkg::RES_W-1:0]  res_next;
  logic [pcls_pkg::FILL_W-1:0] fill_next;
  logic [pcls_pkg::CNT_W-1:0]  dim_cnt_next;
  logic [pcls_pkg::CNT_W-1:0]  byte_cnt_next;
  logic [pcls_pkg::VEC_W-1:0]  vec_cnt_next;
  pcls_pkg::item_meta_t        meta_next;

  logic                          bits_ok;
  logic                          drain;
  logic                          drain_go;
  logic                          accept;
  logic                          byte_step;
  logic                          table_step;
  logic                          lane_step;
  logic                          last;
  logic [pcls_pkg::CNT_W-1:0]    limit;
  logic [pcls_pkg::CNT_W-1:0]    byte_inc;
  logic [pcls_pkg::WORD_W-1:0]   word;
  logic [pcls_pkg::TOTAL_W-1:0]  total;
  logic [pcls_pkg::NCODE_W-1:0]  ncode;
  logic [pcls_pkg::TOTAL_W-1:0]  used;
  logic [pcls_pkg::CODE_W-1:0]   mask;
  logic [DIM_W-1:0]              dim_sum;
  logic [pcls_pkg::CODE_W-1:0]   lane_code [pcls_pkg::LANES];
  logic [DIM_W-1:0]              lane_dim  [pcls_pkg::LANES];
  logic [pcls_pkg::LANES-1:0]    lane_en;
  logic [DIM_W-1:0]              wdim;
  longint                        wval;

  // Handshake: a full code left in the reservoir is consumed first
  assign bits_ok    = (cfg.bits_per_dim >= 3'd2) && (cfg.bits_per_dim <= 3'd4);
  assign drain      = bits_ok && ({1'b0, fill} >= cfg.bits_per_dim);
  assign item_stall = congested || (item_valid && (mode == pcls_pkg::MODE_BYTE) && drain);
  assign drain_go   = item_valid && (mode == pcls_pkg::MODE_BYTE) && drain && !congested;
  assign accept     = item_valid && !item_stall;
  assign byte_step  = accept && (mode == pcls_pkg::MODE_BYTE);
  assign table_step = accept && (mode == pcls_pkg::MODE_TABLE);
  assign lane_step  = (byte_step || drain_go) && bits_ok;

  assign limit = (int'(cfg.dim_count) < MAX_DIMS) ? cfg.dim_count
                                                  : pcls_pkg::CNT_W'(MAX_DIMS);

  // Unpack codes from the reservoir and the new byte, low bit first
  always_comb begin
    if (drain_go) begin
      word  = pcls_pkg::WORD_W'(res);
      total = pcls_pkg::TOTAL_W'(fill);
    end else begin
      word  = (pcls_pkg::WORD_W'(data_byte) << fill) | pcls_pkg::WORD_W'(res);
      total = pcls_pkg::TOTAL_W'(fill) + 4'd8;
    end
    ncode = bits_ok ? pcls_pkg::code_count(total, cfg.bits_per_dim) : '0;
    used  = pcls_pkg::TOTAL_W'(6'(ncode) * 6'(cfg.bits_per_dim));
    mask  = ~(4'hF << cfg.bits_per_dim);
    for (int i = 0; i < pcls_pkg::LANES; i++) begin
      lane_code[i] = pcls_pkg::CODE_W'(word >> (4'(i) * pcls_pkg::TOTAL_W'(cfg.bits_per_dim)))
                     & mask;
      lane_dim[i]  = DIM_W'(dim_cnt) + DIM_W'(i);
      lane_en[i]   = lane_step && (3'(i) < ncode) && (lane_dim[i] < DIM_W'(limit))
                     && (int'(lane_code[i]) < MAX_LEVELS);
    end
  end

  // Route each lane to the bank of its dimension
  always_comb begin
    for (int k = 0; k < pcls_pkg::LANES; k++) begin
      logic [pcls_pkg::LANE_W-1:0] sel;
      sel        = pcls_pkg::LANE_W'(k) - dim_cnt[pcls_pkg::LANE_W-1:0];
      rd_addr[k] = ADDR_W'({lane_dim[sel][ROW_W+1:2], lane_code[sel][LVL_W-1:0]});
    end
  end

  // Table write: saturate the value to the entry width
  always_comb begin
    wdim    = DIM_W'(table_dim);
    wval    = longint'(table_value);
    wr_addr = ADDR_W'({wdim[ROW_W+1:2], table_level[LVL_W-1:0]});
    if (wval > EMAX) begin
      wr_data = ENTRY_BITS'(EMAX);
    end else if (wval < EMIN) begin
      wr_data = ENTRY_BITS'(EMIN);
    end else begin
      wr_data = ENTRY_BITS'(wval);
    end
    wr_en = '0;
    if (table_step && (int'(table_dim) < MAX_DIMS) && (int'(table_level) < MAX_LEVELS)) begin
      wr_en[table_dim[pcls_pkg::LANE_W-1:0]] = 1'b1;
    end
  end

  // Next stream state
  always_comb begin
    byte_inc      = byte_cnt + 11'd1;
    last          = byte_step && (byte_inc == cfg.bytes_per_vector);
    res_next      = res;
    fill_next     = fill;
    dim_cnt_next  = dim_cnt;
    byte_cnt_next = byte_cnt;
    vec_cnt_next  = vec_cnt;
    dim_sum       = DIM_W'(dim_cnt) + DIM_W'(ncode);
    if (lane_step) begin
      res_next  = pcls_pkg::RES_W'(word >> used);
      fill_next = pcls_pkg::FILL_W'(total - used);
      if (dim_cnt < limit) begin
        dim_cnt_next = (dim_sum >= DIM_W'(limit)) ? limit : pcls_pkg::CNT_W'(dim_sum);
      end
    end
    if (byte_step) begin
      byte_cnt_next = byte_inc;
    end
    if (last) begin
      res_next      = '0;
      fill_next     = '0;
      dim_cnt_next  = '0;
      byte_cnt_next = '0;
      vec_cnt_next  = vec_cnt + 24'd1;
    end
    meta_next.last      = last;
    meta_next.vindex    = vec_cnt;
    meta_next.lane_en   = lane_en;
    meta_next.base_bank = dim_cnt[pcls_pkg::LANE_W-1:0];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res          <= '0;
      fill         <= '0;
      dim_cnt      <= '0;
      byte_cnt     <= '0;
      vec_cnt      <= '0;
      meta.last    <= 1'b0;
      meta.lane_en <= '0;
    end else begin
      res          <= res_next;
      fill         <= fill_next;
      dim_cnt      <= dim_cnt_next;
      byte_cnt     <= byte_cnt_next;
      vec_cnt      <= vec_cnt_next;
      meta.last    <= meta_next.last;
      meta.lane_en <= meta_next.lane_en;
    end
    // Metadata payload follows the read data
    meta.vindex    <= meta_next.vindex;
    meta.base_bank <= meta_next.base_bank;
  end

  // Reservoir never holds more than two leftover bits
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("reservoir fill out of range");

  // A drain cycle empties the reservoir
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    drain_go |=> (fill == 2'd0))
    else $error("drain left bits in the reservoir");

  // After any drain a byte yields at most one code per bank
  a_byte_codes: assert property (@(posedge clk) disable iff (rst)
    (byte_step && bits_ok) |-> (ncode <= 3'd4))
    else $error("byte yields more codes than banks");

  // Lanes stay idle without a byte or drain step
  a_lane_idle: assert property (@(posedge clk) disable iff (rst)
    !lane_step |-> (lane_en == '0))
    else $error("lane enabled without a step");

endmodule

// ===== src/pcls_accum.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pcls_accum
// Back end: folds up to four table entries into one saturating clamp over
// two registered levels, applies it to the accumulator and queues results.
// ============================================================================
module pcls_accum #(
  parameter int ENTRY_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  pcls_pkg::item_meta_t                        meta,
  input  logic [pcls_pkg::LANES-1:0][ENTRY_BITS-1:0]  rd_data,
  output logic                                        congested,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic signed [pcls_pkg::SCORE_W-1:0]         score,
  output logic [pcls_pkg::VEC_W-1:0]                  vector_index
);

  pcls_pkg::clamp_fn_t lane_fn [pcls_pkg::LANES];
  pcls_pkg::clamp_fn_t pair_lo_next;
  pcls_pkg::clamp_fn_t pair_hi_next;
  pcls_pkg::clamp_fn_t pair_lo;
  pcls_pkg::clamp_fn_t pair_hi;
  pcls_pkg::clamp_fn_t group_fn;
  logic                         s1_last;
  logic [pcls_pkg::VEC_W-1:0]   s1_vindex;
  logic                         s2_last;
  logic [pcls_pkg::VEC_W-1:0]   s2_vindex;

  logic signed [pcls_pkg::SCORE_W-1:0] acc;
  logic signed [pcls_pkg::SCORE_W-1:0] acc_sum;
  pcls_pkg::wide_t                     acc_wide;

  logic [pcls_pkg::SCORE_W-1:0] q_score [pcls_pkg::RESULT_DEPTH];
  logic [pcls_pkg::VEC_W-1:0]   q_index [pcls_pkg::RESULT_DEPTH];
  logic [pcls_pkg::QPTR_W-1:0]  wr_ptr;
  logic [pcls_pkg::QPTR_W-1:0]  rd_ptr;
  logic [pcls_pkg::QCNT_W-1:0]  count;
  logic [pcls_pkg::PEND_W-1:0]  pending;
  logic                         push;
  logic                         pop;

  // Level one: entries to clamp functions in lane order, fold pairs
  always_comb begin
    for (int i = 0; i < pcls_pkg::LANES; i++) begin
      logic [pcls_pkg::LANE_W-1:0] bank;
      bank = meta.base_bank + pcls_pkg::LANE_W'(i);
      lane_fn[i] = pcls_pkg::CLAMP_IDENTITY;
      if (meta.lane_en[i]) begin
        lane_fn[i].s = pcls_pkg::wide_t'(signed'(rd_data[bank]));
      end
    end
    pair_lo_next = pcls_pkg::compose(lane_fn[0], lane_fn[1]);
    pair_hi_next = pcls_pkg::compose(lane_fn[2], lane_fn[3]);
  end

  // Fold stages; start empty so the accumulator sees no stale group
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_lo  <= pcls_pkg::CLAMP_IDENTITY;
      pair_hi  <= pcls_pkg::CLAMP_IDENTITY;
      group_fn <= pcls_pkg::CLAMP_IDENTITY;
    end else begin
      pair_lo  <= pair_lo_next;
      pair_hi  <= pair_hi_next;
      group_fn <= pcls_pkg::compose(pair_lo, pair_hi);
    end
    s1_vindex <= meta.vindex;
    s2_vindex <= s1_vindex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_last <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      s1_last <= meta.last;
      s2_last <= s1_last;
    end
  end

  // Apply the folded clamp to the accumulator
  assign acc_wide = pcls_pkg::clamp_wide(pcls_pkg::wide_t'(acc) + group_fn.s,
                                         group_fn.lo, group_fn.hi);
  assign acc_sum  = pcls_pkg::SCORE_W'(acc_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_last) begin
      acc <= '0;
    end else begin
      acc <= acc_sum;
    end
  end

  // Result queue
  assign push         = s2_last;
  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign score        = signed'(q_score[rd_ptr]);
  assign vector_index = q_index[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_score[wr_ptr] <= acc_sum;
      q_index[wr_ptr] <= s2_vindex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 3'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 3'd1;
      end
      count <= count + pcls_pkg::QCNT_W'(push) - pcls_pkg::QCNT_W'(pop);
    end
  end

  // Hold off input while in-flight results could overrun the queue
  assign pending   = pcls_pkg::PEND_W'(count) + pcls_pkg::PEND_W'(meta.last)
                   + pcls_pkg::PEND_W'(s1_last) + pcls_pkg::PEND_W'(s2_last);
  assign congested = (pending >= pcls_pkg::PEND_W'(pcls_pkg::RESULT_DEPTH));

  // Every in-flight result has a reserved slot
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= pcls_pkg::PEND_W'(pcls_pkg::RESULT_DEPTH))
    else $error("results in flight exceed queue depth");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < pcls_pkg::QCNT_W'(pcls_pkg::RESULT_DEPTH)))
    else $error("result queue overflow");

  // Accumulator restarts from zero after a vector result
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    s2_last |=> (acc == '0))
    else $error("accumulator not cleared after vector");

endmodule

// ===== src/packed_code_lut_scorer_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// packed_code_lut_scorer_top
// Scores packed 2/3/4-bit code vectors against a per-dimension lookup table
// held in four dimension-interleaved RAM banks, with saturating accumulation.
// ============================================================================
// Results: the end-of-vector flag passes the metadata, level-one and level-two registers
//   before the score is queued. Throughput: one input word per cycle while item_stall is low;
//   the four table banks serve up to four codes per byte. A reservoir holding a whole code
//   after a code-width change is drained before the next byte. Results queue 8 deep.
// Reset: clears counters, reservoir, accumulator and queue; table contents
//   are not cleared and must be written before use.
module packed_code_lut_scorer_top #(
  parameter int MAX_DIMS   = 1024,
  parameter int MAX_LEVELS = 16,
  parameter int ENTRY_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pcls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcls_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  mode,
  input  logic [9:0]                            table_dim,
  input  logic [3:0]                            table_level,
  input  logic signed [15:0]                    table_value,
  input  logic [7:0]                            data_byte,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [pcls_pkg::SCORE_W-1:0]   score,
  output logic [pcls_pkg::VEC_W-1:0]            vector_index
);

  localparam int ROWS       = (MAX_DIMS + pcls_pkg::LANES - 1) / pcls_pkg::LANES;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int BANK_DEPTH = ROWS * (1 << LVL_W);
  localparam int ADDR_W     = $clog2(BANK_DEPTH);

  pcls_pkg::cfg_t       cfg;
  pcls_pkg::item_meta_t meta;
  logic                 congested;

  logic [pcls_pkg::LANES-1:0]                wr_en;
  logic [ADDR_W-1:0]                         wr_addr;
  logic [ENTRY_BITS-1:0]                     wr_data;
  logic [pcls_pkg::LANES-1:0][ADDR_W-1:0]    rd_addr;
  logic [pcls_pkg::LANES-1:0][ENTRY_BITS-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_per_dim     <= pcls_pkg::RST_BITS_PER_DIM;
      cfg.dim_count        <= pcls_pkg::RST_DIM_COUNT;
      cfg.bytes_per_vector <= pcls_pkg::RST_BYTES_PER_VECTOR;
    end else if (cfg_we) begin
      case (cfg_index)
        pcls_pkg::REG_BITS_PER_DIM:     cfg.bits_per_dim     <= cfg_data[pcls_pkg::BITS_W-1:0];
        pcls_pkg::REG_DIM_COUNT:        cfg.dim_count        <= cfg_data;
        pcls_pkg::REG_BYTES_PER_VECTOR: cfg.bytes_per_vector <= cfg_data;
        default: ;
      endcase
    end
  end

  pcls_unpack #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_LEVELS (MAX_LEVELS),
    .ENTRY_BITS (ENTRY_BITS),
    .ADDR_W     (ADDR_W)
  ) u_unpack (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (mode),
    .table_dim   (table_dim),
    .table_level (table_level),
    .table_value (table_value),
    .data_byte   (data_byte),
    .congested   (congested),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .meta        (meta)
  );

  // Table banks, interleaved by dimension
  for (genvar k = 0; k < pcls_pkg::LANES; k++) begin : g_bank
    pcls_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en[k]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr[k]),
      .rdata (rd_data[k])
    );
  end

  pcls_accum #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .meta         (meta),
    .rd_data      (rd_data),
    .congested    (congested),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .score        (score),
    .vector_index (vector_index)
  );

endmodule

// ===== bench/packed_code_lut_scorer_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// packed_code_lut_scorer_top_tb
// Self-checking bench for the packed code lookup table scorer. Preloads every
// level of the low dimensions, then streams table writes and packed vector
// bytes under random sender gaps and receiver stalls across many code widths,
// dimension counts and vector lengths. A local scoring model predicts each
// vector score and index, and a monitor checks every result word in order.
// ============================================================================
module packed_code_lut_scorer_top_tb;

  localparam int     LUT_DIMS    = 1024;
  localparam int     LUT_LEVELS  = 16;
  localparam int     PRE_DIMS    = 16;
  localparam int     ITEM_TARGET = 950;
  localparam longint ACC_HI      = 64'sd2147483647;
  localparam longint ACC_LO      = -64'sd2147483648;

  typedef struct {
    logic              mode;
    logic [9:0]        dim;
    logic [3:0]        level;
    logic signed [15:0] value;
    logic [7:0]        data;
  } word_t;

  typedef struct {
    logic signed [pcls_pkg::SCORE_W-1:0] score;
    logic [pcls_pkg::VEC_W-1:0]          vidx;
  } score_rec_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_t;

  // DUT ports
  logic                                  clk          = 1'b0;
  logic                                  rst          = 1'b1;
  logic                                  cfg_we       = 1'b0;
  logic [pcls_pkg::CFG_IDX_W-1:0]        cfg_index    = pcls_pkg::REG_BITS_PER_DIM;
  logic [pcls_pkg::CFG_DATA_W-1:0]       cfg_data     = '0;
  logic                                  item_valid   = 1'b0;
  logic                                  item_stall;
  logic                                  mode         = pcls_pkg::MODE_TABLE;
  logic [9:0]                            table_dim    = '0;
  logic [3:0]                            table_level  = '0;
  logic signed [15:0]                    table_value  = '0;
  logic [7:0]                            data_byte    = '0;
  logic                                  result_valid;
  logic                                  result_stall = 1'b0;
  logic signed [pcls_pkg::SCORE_W-1:0]   score;
  logic [pcls_pkg::VEC_W-1:0]            vector_index;

  // Scoring model state and register copies
  logic signed [15:0]          lut_mirror [0:LUT_DIMS*LUT_LEVELS-1];
  logic signed [31:0]          acc_mirror       = '0;
  logic [9:0]                  reservoir_mirror = '0;
  logic [3:0]                  fill_mirror      = '0;
  logic [10:0]                 dim_pos          = '0;
  logic [10:0]                 bytes_seen       = '0;
  logic [pcls_pkg::VEC_W-1:0]  vec_pos          = '0;
  logic [2:0]                  cfg_bits         = pcls_pkg::RST_BITS_PER_DIM;
  logic [10:0]                 cfg_dims         = pcls_pkg::RST_DIM_COUNT;
  logic [10:0]                 cfg_bpv          = pcls_pkg::RST_BYTES_PER_VECTOR;

  score_rec_t                  score_expected_q [$];
  word_t                       pending_words [$];
  word_t                       port_word;
  score_rec_t                  oldest;
  bit                          word_on_port   = 1'b0;
  int unsigned                 burst_left     = 1;
  int unsigned                 gap_left       = 0;
  int unsigned                 total_words    = 0;
  int unsigned                 vectors_scored = 0;
  int unsigned                 settings_count = 0;
  int unsigned                 mismatch_count = 0;
  stall_style_t                stall_style    = STALL_NONE;
  int unsigned                 style_left     = 0;
  int unsigned                 run_left       = 0;
  bit                          run_level      = 1'b0;

  packed_code_lut_scorer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .table_dim    (table_dim),
    .table_level  (table_level),
    .table_value  (table_value),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .score        (score),
    .vector_index (vector_index)
  );

  always #2 clk = ~clk;

  // Apply one accepted word to the scoring model; queue a score when a vector ends
  task automatic score_word(input word_t w);
    logic [31:0] res;
    int unsigned fill;
    int unsigned bits;
    int unsigned lim;
    logic [3:0]  code;
    longint      sum;
    if (w.mode == pcls_pkg::MODE_TABLE) begin
      lut_mirror[{w.dim, w.level}] = w.value;
      return;
    end
    bits = cfg_bits;
    if (bits >= 2 && bits <= 4) begin
      res  = {22'd0, reservoir_mirror};
      fill = (fill_mirror > 2) ? 2 : fill_mirror;
      res  = res | (32'(w.data) << fill);
      fill = fill + 8;
      lim  = (cfg_dims < LUT_DIMS) ? cfg_dims : LUT_DIMS;
      // take codes low bit first; codes past the dimension limit are padding
      while (fill >= bits) begin
        code = 4'(res & ((32'd1 << bits) - 1));
        if (dim_pos < lim) begin
          sum = longint'(acc_mirror) + longint'(lut_mirror[{dim_pos[9:0], code}]);
          if (sum > ACC_HI) sum = ACC_HI;
          if (sum < ACC_LO) sum = ACC_LO;
          acc_mirror = 32'(sum);
          dim_pos    = dim_pos + 11'd1;
        end
        res  = res >> bits;
        fill = fill - bits;
      end
      reservoir_mirror = res[9:0];
      fill_mirror      = 4'(fill);
    end
    bytes_seen = bytes_seen + 11'd1;
    if (bytes_seen == cfg_bpv) begin
      score_expected_q.push_back('{score: acc_mirror, vidx: vec_pos});
      acc_mirror       = '0;
      reservoir_mirror = '0;
      fill_mirror      = '0;
      dim_pos          = '0;
      bytes_seen       = '0;
      vec_pos          = vec_pos + 24'd1;
    end
  endtask

  // Sender: present queued words in bursts, hold a stalled word
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        score_word(port_word);
        word_on_port = 1'b0;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          port_word    = pending_words.pop_front();
          word_on_port = 1'b1;
          mode        <= port_word.mode;
          table_dim   <= port_word.dim;
          table_level <= port_word.level;
          table_value <= port_word.value;
          data_byte   <= port_word.data;
          item_valid  <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(10, 30);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern whose style changes after a random run
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(40, 300);
    end
    style_left--;
    case (stall_style)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 12);
          run_level = !run_level;
        end
        run_left--;
        result_stall <= run_level;
      end
    endcase
  end

  // Check each result word against the oldest predicted score
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      vectors_scored++;
      if (score_expected_q.size() == 0) begin
        $error("score: no result expected, got %0d (vector_index %0d)", score, vector_index);
        mismatch_count++;
      end else begin
        oldest = score_expected_q.pop_front();
        if (score !== oldest.score) begin
          $error("score: expected %0d, got %0d", oldest.score, score);
          mismatch_count++;
        end
        if (vector_index !== oldest.vidx) begin
          $error("vector_index: expected %0d, got %0d", oldest.vidx, vector_index);
          mismatch_count++;
        end
      end
    end
  end

  task automatic queue_table(input int unsigned d, input int unsigned l,
                             input logic signed [15:0] v);
    pending_words.push_back('{mode: pcls_pkg::MODE_TABLE, dim: 10'(d), level: 4'(l),
                              value: v, data: 8'($urandom)});
    total_words++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_words.push_back('{mode: pcls_pkg::MODE_BYTE, dim: 10'($urandom),
                              level: 4'($urandom), value: 16'($urandom), data: b});
    total_words++;
  endtask

  // Queue whole vectors with stray table writes mixed in
  task automatic queue_vectors(input int unsigned nv, input int unsigned nbytes);
    logic [7:0] b;
    int unsigned d;
    for (int v = 0; v < nv; v++) begin
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, PRE_DIMS - 1)
                                          : $urandom_range(0, LUT_DIMS - 1);
          queue_table(d, $urandom_range(0, LUT_LEVELS - 1), 16'($urandom));
        end
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        queue_byte(b);
      end
    end
  endtask

  // Wait until every word is taken and every score has come, then let the pipe settle
  task automatic drain();
    while (pending_words.size() != 0 || word_on_port || score_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // Reprogram all three registers while the block is idle
  task automatic program_regs(input int unsigned b, input int unsigned d, input int unsigned v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pcls_pkg::REG_BITS_PER_DIM;
    cfg_data  <= pcls_pkg::CFG_DATA_W'(b);
    @(posedge clk);
    cfg_index <= pcls_pkg::REG_DIM_COUNT;
    cfg_data  <= pcls_pkg::CFG_DATA_W'(d);
    @(posedge clk);
    cfg_index <= pcls_pkg::REG_BYTES_PER_VECTOR;
    cfg_data  <= pcls_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_bits  = 3'(b);
    cfg_dims  = 11'(d);
    cfg_bpv   = 11'(v);
    settings_count++;
  endtask

  // Stimulus
  initial begin
    int unsigned bits;
    int unsigned eff_bits;
    int unsigned dims;
    int unsigned bpv;
    int unsigned nv;
    int unsigned need;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // fill every level of the low dimensions; vectors never reach past them
    for (int d = 0; d < PRE_DIMS; d++) begin
      for (int l = 0; l < LUT_LEVELS; l++) begin
        queue_table(d, l, 16'($urandom));
      end
    end

    // extreme entries, padding codes past the dimension count
    program_regs(2, 3, 1);
    queue_table(0, 3, 16'sh7FFF);
    queue_table(1, 0, 16'sh8000);
    queue_table(2, 2, 16'sh0000);
    queue_byte(8'h23);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    // 3-bit codes straddling bytes, table write inside a vector
    program_regs(3, 1024, 3);
    queue_byte(8'hFF);
    queue_table(1023, 15, 16'sh8000);
    queue_byte(8'h00);
    queue_byte(8'hA5);
    // short vectors drop leftover reservoir bits
    program_regs(3, 5, 1);
    queue_byte(8'h5A);
    queue_byte(8'hC3);
    // unsupported code width scores zero
    program_regs(7, 4, 2);
    queue_byte(8'hFF);
    queue_byte(8'h81);
    program_regs(4, 2, 2);
    queue_byte(8'hF0);
    queue_byte(8'h0F);
    // full dimension count, vector ends inside the loaded dimensions
    program_regs(4, 1024, 8);
    queue_vectors(1, 8);

    // random settings, each phase made of whole vectors
    while (total_words < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       bits = 3'($urandom_range(5, 8));
        default: bits = $urandom_range(2, 4);
      endcase
      case ($urandom_range(0, 5))
        0:       dims = 1;
        1:       dims = 1024;
        default: dims = $urandom_range(1, PRE_DIMS);
      endcase
      eff_bits = (bits >= 2 && bits <= 4) ? bits : 4;
      need     = (dims * eff_bits + 7) / 8;
      if (dims > PRE_DIMS && bits >= 2 && bits <= 4) begin
        // keep codes inside the loaded dimensions
        bpv = $urandom_range(1, 2 * bits);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: bpv = (need <= 24) ? need : $urandom_range(1, 24);
          8:          bpv = $urandom_range(16, 24);
          default:    bpv = $urandom_range(1, 24);
        endcase
      end
      nv = $urandom_range(1, 6);
      program_regs(bits, dims, bpv);
      queue_vectors(nv, bpv);
    end

    drain();
    repeat (12) @(posedge clk);
    $display("Sent %0d words over %0d register settings; %0d vector scores checked.",
             total_words, settings_count, vectors_scored);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
